// ===== hw/rtl/swp_pkg.sv =====
// ----------------------------------------------------------------------------
// swp_pkg: shared types and constants of the skin weight packer
// Field widths, slot record, result record and status codes.
// ----------------------------------------------------------------------------
package swp_pkg;

  // field widths
  localparam int WEIGHT_W   = 18;
  localparam int JOINT_W    = 8;
  localparam int QUO_W      = 8;
  localparam int BIT_W      = 3;
  localparam int SLOTS_W    = 3;
  localparam int STATUS_W   = 2;
  localparam int JLIM_W     = JOINT_W + 1;
  localparam int OUT_SLOTS  = 4;

  // stream widths, padded to whole bytes
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 72;

  // defaults and behavior constants
  localparam int KEPT_SLOTS_DEF = 4;
  localparam int MAX_JOINTS     = 136;
  localparam logic [JOINT_W-1:0] JOINT_COUNT_RST = JOINT_W'(136);
  localparam int QUANT_MAX      = 255;
  localparam int MUL_K          = 2 * QUANT_MAX;

  // one kept influence
  typedef struct packed {
    logic                       vld;
    logic signed [WEIGHT_W-1:0] weight;
    logic [JOINT_W-1:0]         joint;
  } swp_slot_t;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 2'd0,
    ST_SUM_NONPOS = 2'd1,
    ST_BAD_JOINT  = 2'd2
  } swp_status_e;

  // one packed result, first field in the highest bits
  typedef struct packed {
    swp_status_e                          status;
    logic [SLOTS_W-1:0]                   slots_used;
    logic [OUT_SLOTS-1:0][QUO_W-1:0]      byte_w;
    logic [OUT_SLOTS-1:0][JOINT_W-1:0]    joint;
  } swp_result_t;

endpackage

// ===== hw/rtl/top4_skin_weight_packer.sv =====
// ----------------------------------------------------------------------------
// top4_skin_weight_packer: keeps the strongest joint influences of a vertex
// and packs them into joint indices and 8-bit normalized weights.
// ----------------------------------------------------------------------------
// Influences enter one per cycle while the quantizer is idle, into a row of
// KEPT_SLOTS cells that keeps them sorted by weight. The last influence
// hands the row to the quantizer and the row empties at once; the input then
// stalls while the shared bit-serial divider makes one quotient bit per
// cycle, eight per slot. A vertex with an error status skips the divider and
// stalls the input only through the sum and done states, and either stall
// grows while an earlier result still occupies the output register. The
// finished result waits in an output register, so the next vertex streams in
// while it is still pending on the master side. The joint count register is
// written through the cfg channel, which is always ready.
// ----------------------------------------------------------------------------
module top4_skin_weight_packer
  import swp_pkg::*;
#(
  parameter int KEPT_SLOTS = KEPT_SLOTS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // influence stream
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // weight_value[17:0], joint_index[25:18]
  input  logic                   s_axis_tlast,  // last_of_vertex
  // packed vertex stream
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,  // joint_slot0..3, byte_weight0..3,
                                                // slots_used[66:64], status[68:67]
  // joint count register
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [JOINT_W-1:0]     cfg_data_i
);

  logic signed [WEIGHT_W-1:0] in_weight;
  logic [JOINT_W-1:0]         in_joint;
  logic                       in_req;
  logic                       in_end;
  logic                       cur_bad;
  logic [JOINT_W-1:0]         jcount_q;
  logic                       bad_q;
  logic                       q_busy;
  swp_result_t                result;

  logic                       cell_ins  [KEPT_SLOTS];
  swp_slot_t                  cell_slot [KEPT_SLOTS];
  swp_slot_t                  cell_nxt  [KEPT_SLOTS];

  assign in_weight     = s_axis_tdata[WEIGHT_W-1:0];
  assign in_joint      = s_axis_tdata[WEIGHT_W+JOINT_W-1:WEIGHT_W];
  assign s_axis_tready = !q_busy;
  assign in_req        = s_axis_tvalid && s_axis_tready;
  assign in_end        = in_req && s_axis_tlast;
  assign cfg_ready_o   = 1'b1;

  // joint range check against the smaller of register and hard limit
  assign cur_bad = (in_joint >= jcount_q)
                || ({1'b0, in_joint} >= JLIM_W'(MAX_JOINTS));

  // configuration register and sticky bad-joint flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      jcount_q <= JOINT_COUNT_RST;
      bad_q    <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        jcount_q <= cfg_data_i;
      end
      if (in_end) begin
        bad_q <= 1'b0;
      end else if (in_req) begin
        bad_q <= bad_q || cur_bad;
      end
    end
  end

  // insertion row, strongest slot first
  for (genvar k = 0; k < KEPT_SLOTS; k++) begin : g_row
    logic      left_ins;
    swp_slot_t left_slot;
    if (k == 0) begin : g_head
      assign left_ins  = 1'b0;
      assign left_slot = '0;
    end else begin : g_link
      assign left_ins  = cell_ins[k-1];
      assign left_slot = cell_slot[k-1];
    end
    swp_cell u_slot (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .en_i        (in_req),
      .clr_i       (s_axis_tlast),
      .weight_i    (in_weight),
      .joint_i     (in_joint),
      .left_ins_i  (left_ins),
      .left_slot_i (left_slot),
      .ins_o       (cell_ins[k]),
      .slot_o      (cell_slot[k]),
      .nxt_o       (cell_nxt[k])
    );
  end

  // per-vertex quantizer and output register
  swp_quant #(
    .KEPT_SLOTS (KEPT_SLOTS)
  ) u_quant (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (in_end),
    .slots_i     (cell_nxt),
    .bad_i       (bad_q || cur_bad),
    .busy_o      (q_busy),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .result_o    (result)
  );

  assign m_axis_tdata = {{(OUT_TDATA_W - $bits(swp_result_t)){1'b0}}, result};

`ifndef NO_ASSERTIONS
  // the quantizer takes the vertex, so input stalls right after it
  a_end_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_end |=> !s_axis_tready)
    else $error("input not stalled after last influence");

  // row is empty for the next vertex
  a_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_end |=> !cell_slot[0].vld)
    else $error("insertion row not cleared after last influence");

  // a result always reports at least one slot
  a_slots_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (result.slots_used != '0))
    else $error("result with no used slot");

  // kept slots stay packed and in descending order
  for (genvar k = 1; k < KEPT_SLOTS; k++) begin : g_chk
    a_packed: assert property (@(posedge clk_i) disable iff (!rst_ni)
      cell_slot[k].vld |-> cell_slot[k-1].vld)
      else $error("gap in kept slots");
    a_sorted: assert property (@(posedge clk_i) disable iff (!rst_ni)
      cell_slot[k].vld |-> (cell_slot[k-1].weight >= cell_slot[k].weight))
      else $error("kept slots out of order");
  end
`endif

endmodule

// ===== hw/rtl/swp_cell.sv =====
// ----------------------------------------------------------------------------
// swp_cell: one slot of the top-k insertion row
// Holds one kept influence; on a request it keeps its entry, takes the new
// influence, or takes the entry of its left neighbor that was pushed down.
// ----------------------------------------------------------------------------
module swp_cell
  import swp_pkg::*;
(
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       clr_i,
  input  logic signed [WEIGHT_W-1:0] weight_i,
  input  logic [JOINT_W-1:0]         joint_i,
  input  logic                       left_ins_i,
  input  swp_slot_t                  left_slot_i,
  output logic                       ins_o,
  output swp_slot_t                  slot_o,
  output swp_slot_t                  nxt_o
);

  swp_slot_t slot_q;
  swp_slot_t new_slot;

  // strictly larger weight wins, so an equal weight stays behind the earlier one
  assign ins_o  = !slot_q.vld || (weight_i > slot_q.weight);
  assign slot_o = slot_q;

  // next content if the request is taken
  always_comb begin
    new_slot.vld    = 1'b1;
    new_slot.weight = weight_i;
    new_slot.joint  = joint_i;
    if (!ins_o) begin
      nxt_o = slot_q;
    end else if (left_ins_i) begin
      nxt_o = left_slot_i;
    end else begin
      nxt_o = new_slot;
    end
  end

  // slot register, emptied after the last influence of a vertex
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= '0;
    end else if (en_i) begin
      slot_q <= clr_i ? swp_slot_t'('0) : nxt_o;
    end
  end

endmodule

// ===== hw/rtl/swp_quant.sv =====
// ----------------------------------------------------------------------------
// swp_quant: per-vertex weight quantizer
// Sums the kept weights, divides each by the sum one quotient bit per cycle,
// applies the residual to slot 0 and holds the result in an output register.
// ----------------------------------------------------------------------------
module swp_quant
  import swp_pkg::*;
#(
  parameter int KEPT_SLOTS = KEPT_SLOTS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        load_i,
  input  swp_slot_t   slots_i [KEPT_SLOTS],
  input  logic        bad_i,
  output logic        busy_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output swp_result_t result_o
);

  localparam int SUM_W   = WEIGHT_W + $clog2(KEPT_SLOTS) + 1;
  localparam int QW      = SUM_W + QUO_W;
  localparam int IDX_W   = (KEPT_SLOTS > 1) ? $clog2(KEPT_SLOTS) : 1;
  localparam int CNT_W   = $clog2(KEPT_SLOTS + 1);
  localparam int TOT_W   = QUO_W + $clog2(KEPT_SLOTS) + 1;
  localparam int FIX_W   = TOT_W + 2;
  localparam int NUM_OUT = (KEPT_SLOTS < OUT_SLOTS) ? KEPT_SLOTS : OUT_SLOTS;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SUM,
    S_LOAD,
    S_DIV,
    S_STORE,
    S_FIX,
    S_DONE
  } state_e;

  state_e                   state_q;
  swp_slot_t                slot_q [KEPT_SLOTS];
  logic [QUO_W-1:0]         q_q    [KEPT_SLOTS];
  logic                     bad_q;
  logic signed [SUM_W-1:0]  sum_q;
  swp_status_e              status_q;
  logic [CNT_W-1:0]         cnt_q;
  logic [IDX_W-1:0]         idx_q;
  logic [BIT_W-1:0]         bit_q;
  logic [QW-1:0]            r_q;
  logic [QW-1:0]            dsh_q;
  logic [QUO_W-1:0]         quo_q;
  logic                     out_valid_q;
  swp_result_t              result_q;

  logic signed [SUM_W-1:0]  sum_c;
  logic [CNT_W-1:0]         cnt_c;
  swp_status_e              status_c;
  swp_slot_t                cur;
  logic [WEIGHT_W-2:0]      wpos;
  logic [QW-1:0]            num_c;
  logic [QW-1:0]            dinit_c;
  logic                     ge;
  logic [QUO_W-1:0]         qval_c;
  logic [TOT_W-1:0]         total_c;
  logic signed [FIX_W-1:0]  fix_c;
  logic [QUO_W-1:0]         fix_clamp;
  swp_result_t              res_c;

  // sum, count and status over the captured slots
  always_comb begin
    sum_c = '0;
    cnt_c = '0;
    for (int k = 0; k < KEPT_SLOTS; k++) begin
      if (slot_q[k].vld) begin
        sum_c = sum_c + SUM_W'(slot_q[k].weight);
        cnt_c = cnt_c + CNT_W'(1);
      end
    end
    if (bad_q) begin
      status_c = ST_BAD_JOINT;
    end else if (sum_c[SUM_W-1] || (sum_c == '0)) begin
      status_c = ST_SUM_NONPOS;
    end else begin
      status_c = ST_OK;
    end
  end

  // dividend 2*w*255 + sum and divisor 2*sum aligned to the top quotient bit
  always_comb begin
    cur     = slot_q[idx_q];
    wpos    = (cur.weight > 0) ? cur.weight[WEIGHT_W-2:0] : '0;
    num_c   = QW'(MUL_K) * QW'(wpos) + QW'($unsigned(sum_q));
    dinit_c = QW'($unsigned(sum_q)) << QUO_W;
    ge      = (r_q >= dsh_q);
  end

  // quantized weight of the current slot
  always_comb begin
    if (!cur.vld || !(cur.weight > 0)) begin
      qval_c = '0;
    end else if (SUM_W'(cur.weight) >= sum_q) begin
      qval_c = QUO_W'(QUANT_MAX);
    end else begin
      qval_c = quo_q;
    end
  end

  // residual correction on slot 0
  always_comb begin
    total_c = '0;
    for (int k = 0; k < KEPT_SLOTS; k++) begin
      total_c = total_c + TOT_W'(q_q[k]);
    end
    fix_c = signed'(FIX_W'(q_q[0])) + signed'(FIX_W'(QUANT_MAX))
          - signed'(FIX_W'(total_c));
    if (fix_c[FIX_W-1]) begin
      fix_clamp = '0;
    end else if (fix_c > signed'(FIX_W'(QUANT_MAX))) begin
      fix_clamp = QUO_W'(QUANT_MAX);
    end else begin
      fix_clamp = fix_c[QUO_W-1:0];
    end
  end

  // result assembly, unused slots read as zero
  always_comb begin
    res_c            = '0;
    res_c.status     = status_q;
    res_c.slots_used = SLOTS_W'(cnt_q);
    for (int k = 0; k < NUM_OUT; k++) begin
      if (slot_q[k].vld) begin
        res_c.joint[k]  = slot_q[k].joint;
        res_c.byte_w[k] = q_q[k];
      end
    end
  end

  // sequencer with output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      result_q    <= '0;
      bad_q       <= 1'b0;
      sum_q       <= '0;
      status_q    <= ST_OK;
      cnt_q       <= '0;
      idx_q       <= '0;
      bit_q       <= '0;
      r_q         <= '0;
      dsh_q       <= '0;
      quo_q       <= '0;
      for (int k = 0; k < KEPT_SLOTS; k++) begin
        slot_q[k] <= '0;
        q_q[k]    <= '0;
      end
    end else begin
      if (out_valid_q && out_ready_i && (state_q != S_DONE)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (load_i) begin
            for (int k = 0; k < KEPT_SLOTS; k++) begin
              slot_q[k] <= slots_i[k];
            end
            bad_q   <= bad_i;
            state_q <= S_SUM;
          end
        end
        S_SUM: begin
          sum_q    <= sum_c;
          status_q <= status_c;
          cnt_q    <= cnt_c;
          idx_q    <= '0;
          for (int k = 0; k < KEPT_SLOTS; k++) begin
            q_q[k] <= '0;
          end
          state_q  <= (status_c == ST_OK) ? S_LOAD : S_DONE;
        end
        S_LOAD: begin
          r_q     <= num_c;
          dsh_q   <= dinit_c;
          bit_q   <= BIT_W'(QUO_W - 1);
          state_q <= S_DIV;
        end
        S_DIV: begin
          if (ge) begin
            r_q <= r_q - dsh_q;
          end
          quo_q <= {quo_q[QUO_W-2:0], ge};
          dsh_q <= dsh_q >> 1;
          bit_q <= bit_q - BIT_W'(1);
          if (bit_q == '0) begin
            state_q <= S_STORE;
          end
        end
        S_STORE: begin
          q_q[idx_q] <= qval_c;
          if (idx_q == IDX_W'(KEPT_SLOTS - 1)) begin
            state_q <= S_FIX;
          end else begin
            idx_q   <= idx_q + IDX_W'(1);
            state_q <= S_LOAD;
          end
        end
        S_FIX: begin
          q_q[0]  <= fix_clamp;
          state_q <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid_q || out_ready_i) begin
            result_q    <= res_c;
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign busy_o      = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign result_o    = result_q;

endmodule
